>>> hw/rtl/cif_pkg.sv
package cif_pkg;

  localparam int BUF_DEPTH = 128;                  // power of two, 2..4096
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int PTR_W     = IDX_W + 1;            // one extra bit tells full from empty

  localparam int IN_W  = 16;                       // ch, first_of_read, zero pad
  localparam int OUT_W = 40;                       // nine result fields, zero pad

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INT  = 2'd1;
  localparam logic [1:0] SIG_STOP = 2'd2;
  localparam logic [1:0] SIG_DUMP = 2'd3;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic accept;   // latch item, start store read
    logic exec;     // evaluate item, update state, load result
  } cmd_t;

  typedef struct packed {
    logic out_free; // result register empty or being drained
  } sts_t;

endpackage

>>> hw/rtl/cif_ctrl.sv
module cif_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cif_pkg::sts_t sts,
  output cif_pkg::cmd_t cmd
);

  cif_pkg::state_t state_r, state_nxt;

  assign in_tready  = (state_r == cif_pkg::ST_IDLE);
  assign cmd.accept = in_tvalid && in_tready;
  assign cmd.exec   = (state_r == cif_pkg::ST_EXEC) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cif_pkg::ST_IDLE: begin
        if (cmd.accept) state_nxt = cif_pkg::ST_EXEC;
      end
      cif_pkg::ST_EXEC: begin
        if (cmd.exec) state_nxt = cif_pkg::ST_IDLE;
      end
      default: state_nxt = cif_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cif_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> hw/rtl/cif_datapath.sv
module cif_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cif_pkg::cmd_t             cmd,
  output cif_pkg::sts_t             sts,
  input  logic                      in_op,
  input  logic [cif_pkg::IN_W-1:0]  in_data,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cif_pkg::OUT_W-1:0] out_data
);

  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_INTR = 8'h03;
  localparam logic [7:0] CH_SUSP = 8'h1a;
  localparam logic [7:0] CH_DUMP = 8'h10;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_DEL  = 8'h7f;
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_LBR  = 8'h5b;
  localparam logic [7:0] CH_UP   = 8'h41;
  localparam logic [7:0] CH_DOWN = 8'h42;
  localparam logic [7:0] KEY_UP  = 8'h01;
  localparam logic [7:0] KEY_DN  = 8'h02;

  localparam int PW = cif_pkg::PTR_W;
  localparam int IW = cif_pkg::IDX_W;

  logic [7:0]    mem [cif_pkg::BUF_DEPTH];
  logic [7:0]    rdata_r;

  logic          op_r;
  logic [7:0]    ch_r;
  logic          first_r;

  logic [PW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic          esc_r, esc_nxt, sb_r, sb_nxt;
  logic [15:0]   fg_r;

  logic                      out_valid_r;
  logic [cif_pkg::OUT_W-1:0] out_data_r;

  logic [PW-1:0] fill;
  logic          full, empty;
  logic          enq;
  logic [7:0]    enq_byte;
  logic          mem_we;

  logic          echo_valid, read_valid, read_eof, read_line_end, read_empty;
  logic [7:0]    echo_byte, read_byte;
  logic [1:0]    signal_kind;
  logic [15:0]   signal_group;

  assign fill  = wr_r - rd_r;
  assign full  = (fill == PW'(cif_pkg::BUF_DEPTH));
  assign empty = (fill == '0);

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_comb begin
    rd_nxt        = rd_r;
    esc_nxt       = esc_r;
    sb_nxt        = sb_r;
    enq           = 1'b0;
    enq_byte      = 8'h00;
    echo_valid    = 1'b0;
    echo_byte     = 8'h00;
    signal_kind   = cif_pkg::SIG_NONE;
    signal_group  = 16'h0000;
    read_valid    = 1'b0;
    read_byte     = 8'h00;
    read_eof      = 1'b0;
    read_line_end = 1'b0;
    read_empty    = 1'b0;

    if (op_r == cif_pkg::OP_READ) begin
      if (empty) begin
        read_empty = 1'b1;
      end else if (rdata_r == CH_EOT) begin
        read_eof = 1'b1;
        if (first_r) rd_nxt = rd_r + PW'(1);
      end else begin
        rd_nxt        = rd_r + PW'(1);
        read_valid    = 1'b1;
        read_byte     = rdata_r;
        read_line_end = (rdata_r == CH_LF);
      end
    end else if (esc_r) begin
      if (ch_r == CH_LBR) begin
        sb_nxt = 1'b1;
      end else if (sb_r && (ch_r inside {[8'h30:8'h39], 8'h3b, 8'h3f})) begin
        // swallow parameter bytes of the sequence
      end else begin
        esc_nxt = 1'b0;
        sb_nxt  = 1'b0;
        if (ch_r == CH_UP) begin
          enq      = 1'b1;
          enq_byte = KEY_UP;
        end else if (ch_r == CH_DOWN) begin
          enq      = 1'b1;
          enq_byte = KEY_DN;
        end
      end
    end else begin
      case (ch_r)
        CH_ESC: begin
          esc_nxt = 1'b1;
          sb_nxt  = 1'b0;
        end
        CH_INTR: begin
          if (fg_r != 16'h0000) begin
            signal_kind  = cif_pkg::SIG_INT;
            signal_group = fg_r;
          end
        end
        CH_SUSP: begin
          if (fg_r != 16'h0000) begin
            signal_kind  = cif_pkg::SIG_STOP;
            signal_group = fg_r;
          end
        end
        CH_DUMP: signal_kind = cif_pkg::SIG_DUMP;
        CH_KILL: begin
          enq      = 1'b1;
          enq_byte = CH_KILL;
        end
        CH_BS, CH_DEL: begin
          enq      = 1'b1;
          enq_byte = CH_BS;
        end
        default: begin
          if (ch_r != 8'h00 && !full) begin
            echo_valid = 1'b1;
            echo_byte  = (ch_r == CH_CR) ? CH_LF : ch_r;
            enq        = 1'b1;
            enq_byte   = echo_byte;
          end
        end
      endcase
    end

    mem_we = cmd.exec && enq && !full;
    wr_nxt = mem_we ? wr_r + PW'(1) : wr_r;
  end

  // ring store, registered read at accept time
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_r[IW-1:0]] <= enq_byte;
    if (cmd.accept) rdata_r <= mem[rd_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      ch_r    <= in_data[7:0];
      first_r <= in_data[8];
    end
    if (cmd.exec) begin
      out_data_r <= {1'b0, read_empty, read_line_end, read_eof, read_byte, read_valid,
                     signal_group, signal_kind, echo_byte, echo_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= '0;
      wr_r        <= '0;
      esc_r       <= 1'b0;
      sb_r        <= 1'b0;
      fg_r        <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) fg_r <= cfg_wr_data;
      if (cmd.exec) begin
        rd_r        <= rd_nxt;
        wr_r        <= wr_nxt;
        esc_r       <= esc_nxt;
        sb_r        <= sb_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= PW'(cif_pkg::BUF_DEPTH))
    else $error("ring fill exceeds depth");

  a_bracket_in_esc: assert property (@(posedge clk) disable iff (!rst_n)
    sb_r |-> esc_r)
    else $error("bracket flag set outside an escape");

  a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && read_valid) |=> (rd_r == $past(rd_r) + PW'(1)))
    else $error("delivered byte did not advance read pointer");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0({echo_valid, signal_kind != cif_pkg::SIG_NONE,
                           read_valid, read_eof, read_empty}))
    else $error("result carries more than one outcome");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !mem_we)
    else $error("write into full ring");

endmodule

>>> hw/rtl/console_input_filter_fifo_unit.sv
// Channel   Direction  Payload
// in_*      slave      tuser: op | tdata: ch[7:0], first_of_read[8], zero pad [15:9]
// out_*     master     tdata: echo_valid, echo_byte, signal_kind, signal_group,
//                      read_valid, read_byte, read_eof, read_line_end, read_empty
// cfg_*     write      foreground_group, written whenever cfg_wr_en is high
//
// Each item is accepted in ST_IDLE, which starts the registered ring read at the read
// pointer; ST_EXEC then evaluates the item and loads the result register once it is
// free, so a new item is accepted only after the last one has been evaluated.
// A result waiting on out_tready does not block the next accept; evaluation of that
// next item holds until the result register drains.
// Reset (rst_n low, synchronous) clears pointers, escape flags, group and result valid.
module console_input_filter_fifo_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cif_pkg::IN_W-1:0]  in_tdata,   // ch[7:0], first_of_read[8], zero[15:9]
  input  logic                      in_tuser,   // op: 0 receive, 1 read
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cif_pkg::OUT_W-1:0] out_tdata,  // echo_valid[0], echo_byte[8:1],
                                                // signal_kind[10:9], signal_group[26:11],
                                                // read_valid[27], read_byte[35:28],
                                                // read_eof[36], read_line_end[37],
                                                // read_empty[38], zero[39]
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data
);

  cif_pkg::cmd_t cmd;
  cif_pkg::sts_t sts;

  // sequence accept and evaluate, one item in flight
  cif_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // filter, ring store, pointers and result register
  cif_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_tuser),
    .in_data     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule
